// ----- sv/maes_pkg.sv -----
// Package for the masked AES-128 encryption block.
// Holds payload structs, the S-box, xtime and round-constant helpers. No dependencies.
package maes_pkg;

  typedef struct packed {
    logic [63:0] plaintext_hi;
    logic [63:0] plaintext_lo;
    logic [7:0]  sbox_in_mask;
    logic [7:0]  sbox_out_mask;
    logic [7:0]  row0_mask;
    logic [7:0]  row1_mask;
    logic [7:0]  row2_mask;
    logic [7:0]  row3_mask;
  } in_word_t;

  typedef struct packed {
    logic [63:0] ciphertext_hi;
    logic [63:0] ciphertext_lo;
  } out_word_t;

  // Data carried from one round cell to the next.
  typedef struct packed {
    logic         vld;
    logic [127:0] state;
    logic [127:0] rkey;
    logic [7:0]   mi;
    logic [7:0]   mo;
    logic [31:0]  rm;
    logic [31:0]  rmx;
  } stage_t;

  localparam logic [0:0] REG_KEY_HI = 1'b0;
  localparam logic [0:0] REG_KEY_LO = 1'b1;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7C; 8'h02: r=8'h77; 8'h03: r=8'h7B;
      8'h04: r=8'hF2; 8'h05: r=8'h6B; 8'h06: r=8'h6F; 8'h07: r=8'hC5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0A: r=8'h67; 8'h0B: r=8'h2B;
      8'h0C: r=8'hFE; 8'h0D: r=8'hD7; 8'h0E: r=8'hAB; 8'h0F: r=8'h76;
      8'h10: r=8'hCA; 8'h11: r=8'h82; 8'h12: r=8'hC9; 8'h13: r=8'h7D;
      8'h14: r=8'hFA; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hF0;
      8'h18: r=8'hAD; 8'h19: r=8'hD4; 8'h1A: r=8'hA2; 8'h1B: r=8'hAF;
      8'h1C: r=8'h9C; 8'h1D: r=8'hA4; 8'h1E: r=8'h72; 8'h1F: r=8'hC0;
      8'h20: r=8'hB7; 8'h21: r=8'hFD; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3F; 8'h26: r=8'hF7; 8'h27: r=8'hCC;
      8'h28: r=8'h34; 8'h29: r=8'hA5; 8'h2A: r=8'hE5; 8'h2B: r=8'hF1;
      8'h2C: r=8'h71; 8'h2D: r=8'hD8; 8'h2E: r=8'h31; 8'h2F: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hC7; 8'h32: r=8'h23; 8'h33: r=8'hC3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9A;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3A: r=8'h80; 8'h3B: r=8'hE2;
      8'h3C: r=8'hEB; 8'h3D: r=8'h27; 8'h3E: r=8'hB2; 8'h3F: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2C; 8'h43: r=8'h1A;
      8'h44: r=8'h1B; 8'h45: r=8'h6E; 8'h46: r=8'h5A; 8'h47: r=8'hA0;
      8'h48: r=8'h52; 8'h49: r=8'h3B; 8'h4A: r=8'hD6; 8'h4B: r=8'hB3;
      8'h4C: r=8'h29; 8'h4D: r=8'hE3; 8'h4E: r=8'h2F; 8'h4F: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hD1; 8'h52: r=8'h00; 8'h53: r=8'hED;
      8'h54: r=8'h20; 8'h55: r=8'hFC; 8'h56: r=8'hB1; 8'h57: r=8'h5B;
      8'h58: r=8'h6A; 8'h59: r=8'hCB; 8'h5A: r=8'hBE; 8'h5B: r=8'h39;
      8'h5C: r=8'h4A; 8'h5D: r=8'h4C; 8'h5E: r=8'h58; 8'h5F: r=8'hCF;
      8'h60: r=8'hD0; 8'h61: r=8'hEF; 8'h62: r=8'hAA; 8'h63: r=8'hFB;
      8'h64: r=8'h43; 8'h65: r=8'h4D; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hF9; 8'h6A: r=8'h02; 8'h6B: r=8'h7F;
      8'h6C: r=8'h50; 8'h6D: r=8'h3C; 8'h6E: r=8'h9F; 8'h6F: r=8'hA8;
      8'h70: r=8'h51; 8'h71: r=8'hA3; 8'h72: r=8'h40; 8'h73: r=8'h8F;
      8'h74: r=8'h92; 8'h75: r=8'h9D; 8'h76: r=8'h38; 8'h77: r=8'hF5;
      8'h78: r=8'hBC; 8'h79: r=8'hB6; 8'h7A: r=8'hDA; 8'h7B: r=8'h21;
      8'h7C: r=8'h10; 8'h7D: r=8'hFF; 8'h7E: r=8'hF3; 8'h7F: r=8'hD2;
      8'h80: r=8'hCD; 8'h81: r=8'h0C; 8'h82: r=8'h13; 8'h83: r=8'hEC;
      8'h84: r=8'h5F; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hC4; 8'h89: r=8'hA7; 8'h8A: r=8'h7E; 8'h8B: r=8'h3D;
      8'h8C: r=8'h64; 8'h8D: r=8'h5D; 8'h8E: r=8'h19; 8'h8F: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4F; 8'h93: r=8'hDC;
      8'h94: r=8'h22; 8'h95: r=8'h2A; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hEE; 8'h9A: r=8'hB8; 8'h9B: r=8'h14;
      8'h9C: r=8'hDE; 8'h9D: r=8'h5E; 8'h9E: r=8'h0B; 8'h9F: r=8'hDB;
      8'hA0: r=8'hE0; 8'hA1: r=8'h32; 8'hA2: r=8'h3A; 8'hA3: r=8'h0A;
      8'hA4: r=8'h49; 8'hA5: r=8'h06; 8'hA6: r=8'h24; 8'hA7: r=8'h5C;
      8'hA8: r=8'hC2; 8'hA9: r=8'hD3; 8'hAA: r=8'hAC; 8'hAB: r=8'h62;
      8'hAC: r=8'h91; 8'hAD: r=8'h95; 8'hAE: r=8'hE4; 8'hAF: r=8'h79;
      8'hB0: r=8'hE7; 8'hB1: r=8'hC8; 8'hB2: r=8'h37; 8'hB3: r=8'h6D;
      8'hB4: r=8'h8D; 8'hB5: r=8'hD5; 8'hB6: r=8'h4E; 8'hB7: r=8'hA9;
      8'hB8: r=8'h6C; 8'hB9: r=8'h56; 8'hBA: r=8'hF4; 8'hBB: r=8'hEA;
      8'hBC: r=8'h65; 8'hBD: r=8'h7A; 8'hBE: r=8'hAE; 8'hBF: r=8'h08;
      8'hC0: r=8'hBA; 8'hC1: r=8'h78; 8'hC2: r=8'h25; 8'hC3: r=8'h2E;
      8'hC4: r=8'h1C; 8'hC5: r=8'hA6; 8'hC6: r=8'hB4; 8'hC7: r=8'hC6;
      8'hC8: r=8'hE8; 8'hC9: r=8'hDD; 8'hCA: r=8'h74; 8'hCB: r=8'h1F;
      8'hCC: r=8'h4B; 8'hCD: r=8'hBD; 8'hCE: r=8'h8B; 8'hCF: r=8'h8A;
      8'hD0: r=8'h70; 8'hD1: r=8'h3E; 8'hD2: r=8'hB5; 8'hD3: r=8'h66;
      8'hD4: r=8'h48; 8'hD5: r=8'h03; 8'hD6: r=8'hF6; 8'hD7: r=8'h0E;
      8'hD8: r=8'h61; 8'hD9: r=8'h35; 8'hDA: r=8'h57; 8'hDB: r=8'hB9;
      8'hDC: r=8'h86; 8'hDD: r=8'hC1; 8'hDE: r=8'h1D; 8'hDF: r=8'h9E;
      8'hE0: r=8'hE1; 8'hE1: r=8'hF8; 8'hE2: r=8'h98; 8'hE3: r=8'h11;
      8'hE4: r=8'h69; 8'hE5: r=8'hD9; 8'hE6: r=8'h8E; 8'hE7: r=8'h94;
      8'hE8: r=8'h9B; 8'hE9: r=8'h1E; 8'hEA: r=8'h87; 8'hEB: r=8'hE9;
      8'hEC: r=8'hCE; 8'hED: r=8'h55; 8'hEE: r=8'h28; 8'hEF: r=8'hDF;
      8'hF0: r=8'h8C; 8'hF1: r=8'hA1; 8'hF2: r=8'h89; 8'hF3: r=8'h0D;
      8'hF4: r=8'hBF; 8'hF5: r=8'hE6; 8'hF6: r=8'h42; 8'hF7: r=8'h68;
      8'hF8: r=8'h41; 8'hF9: r=8'h99; 8'hFA: r=8'h2D; 8'hFB: r=8'h0F;
      8'hFC: r=8'hB0; 8'hFD: r=8'h54; 8'hFE: r=8'hBB; 8'hFF: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return a[7] ? ({a[6:0], 1'b0} ^ 8'h1B) : {a[6:0], 1'b0};
  endfunction

  // MixColumns of one column; byte 0 in bits 31:24.
  function automatic logic [31:0] mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
            xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  // Round constant for round r (1..10).
  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd1: v = 8'h01; 4'd2: v = 8'h02; 4'd3: v = 8'h04; 4'd4: v = 8'h08;
      4'd5: v = 8'h10; 4'd6: v = 8'h20; 4'd7: v = 8'h40; 4'd8: v = 8'h80;
      4'd9: v = 8'h1B; 4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/maes_round.sv -----
// One round cell of the masked AES-128 pipeline: masked SubBytes, ShiftRows,
// optional MixColumns, on-the-fly key step. Depends on maes_pkg.
module maes_round import maes_pkg::*; #(
  parameter logic [3:0] RND  = 4'd1,
  parameter bit         LAST = 1'b0
) (
  input  logic   clk,
  input  logic   rst,
  input  stage_t din,
  output stage_t dout
);

  logic [7:0]   s  [16];
  logic [7:0]   t  [16];
  logic [7:0]   u  [16];
  logic [7:0]   k  [16];
  logic [7:0]   kn [16];
  logic [127:0] st_next;
  logic [127:0] k_next;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = din.state[127 - 8*i -: 8];
      k[i] = din.rkey[127 - 8*i -: 8];
      t[i] = sbox(s[i] ^ din.mi) ^ din.mo;
    end
    // ShiftRows, then (except in the last round) swap the output mask for the row mask.
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        u[4*c + r] = t[4*((c + r) % 4) + r];
        if (!LAST) u[4*c + r] = u[4*c + r] ^ din.mo ^ din.rm[31 - 8*r -: 8];
      end
    end
    kn[0] = k[0] ^ rcon(RND) ^ sbox(k[13]);
    kn[1] = k[1] ^ sbox(k[14]);
    kn[2] = k[2] ^ sbox(k[15]);
    kn[3] = k[3] ^ sbox(k[12]);
    for (int i = 4; i < 16; i++) kn[i] = k[i] ^ kn[i - 4];
    for (int i = 0; i < 16; i++) k_next[127 - 8*i -: 8] = kn[i];
    for (int c = 0; c < 4; c++) begin
      logic [31:0] col;
      col = {u[4*c], u[4*c+1], u[4*c+2], u[4*c+3]};
      if (!LAST) begin
        col = mix_col(col) ^ din.rmx ^ {4{din.mi}};
      end else begin
        col = col ^ {4{din.mo}};
      end
      st_next[127 - 32*c -: 32] = col ^ k_next[127 - 32*c -: 32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
    dout.state <= st_next;
    dout.rkey  <= k_next;
    dout.mi    <= din.mi;
    dout.mo    <= din.mo;
    dout.rm    <= din.rm;
    dout.rmx   <= din.rmx;
  end

endmodule

// ----- sv/masked_aes128_encrypt_top.sv -----
// Top level of the masked AES-128 encryption block: key registers, input
// cell and a chain of ROUNDS round cells. Depends on maes_pkg and maes_round.
//
// Usage: load the key through the cfg channel (index 0 = key_hi, 1 = key_lo;
// other indexes are ignored; cfg_ready is always high). Then present a word
// on din with start high; busy is always low, so a word is taken every cycle
// start is high. Each word carries plaintext and six fresh mask bytes.
// The result word appears on dout with done high for one cycle: the entry
// cell registers the initial key addition and masking at the edge that took
// the word, then one cell per round registers that round in turn.
// Throughput is one block per cycle,
// set by the unrolled chain of round cells. The receiver cannot stall, and
// results are never held back. Reset clears the key to zero and drops every
// word in flight. Change the key only with no word in flight.
module masked_aes128_encrypt_top import maes_pkg::*; #(
  parameter int ROUNDS = 10
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_word_t  din,
  output logic      done,
  output out_word_t dout,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] key_hi;
  logic [63:0] key_lo;
  stage_t      chain [ROUNDS + 1];
  logic [31:0] rm_in;
  logic [31:0] rmx_in;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_hi <= '0;
      key_lo <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_HI: key_hi <= cfg_data;
        REG_KEY_LO: key_lo <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rm_in  = {din.row0_mask, din.row1_mask, din.row2_mask, din.row3_mask};
  assign rmx_in = mix_col(rm_in);

  // Entry cell: plaintext under the input mask, plus the round-0 key.
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].vld <= 1'b0;
    end else begin
      chain[0].vld <= start && !busy;
    end
    chain[0].state <= {din.plaintext_hi, din.plaintext_lo} ^ {key_hi, key_lo}
                      ^ {16{din.sbox_in_mask}};
    chain[0].rkey  <= {key_hi, key_lo};
    chain[0].mi    <= din.sbox_in_mask;
    chain[0].mo    <= din.sbox_out_mask;
    chain[0].rm    <= rm_in;
    chain[0].rmx   <= rmx_in;
  end

  for (genvar g = 1; g <= ROUNDS; g++) begin : g_round
    maes_round #(
      .RND  (4'(g)),
      .LAST (g == ROUNDS)
    ) u_round (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[g - 1]),
      .dout (chain[g])
    );
  end

  assign done               = chain[ROUNDS].vld;
  assign dout.ciphertext_hi = chain[ROUNDS].state[127:64];
  assign dout.ciphertext_lo = chain[ROUNDS].state[63:0];

  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    chain[0].vld |-> ##(ROUNDS) (done || $past(rst, ROUNDS)))
    else $error("result strobe missing after fixed latency");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !chain[0].vld |-> ##(ROUNDS) !done)
    else $error("result strobe without an accepted word");
  a_never_busy: assert property (@(posedge clk) !busy && cfg_ready)
    else $error("pipeline must always accept");

endmodule
